FILE: src/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// immediate implication checked every clock
`define ASSERT_IMP(lbl, clk, rst_n, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
// next-cycle implication
`define ASSERT_NXT(lbl, clk, rst_n, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

FILE: src/mws_pkg.sv
// package for the mecanum wheel speed controller
package mws_pkg;
  localparam int unsigned FracBitsDef = 8;
  localparam int unsigned Wheels = 4;
  localparam int unsigned TurnClamp = 400;
  // divide by five as a multiply: (2^26 + 1) / 5, exact below 2^26
  localparam int unsigned TurnRecip = 13421773;
  localparam int unsigned TurnRecipSh = 26;
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] RegProp = 3'd0;
  localparam logic [CfgIdxW-1:0] RegInt = 3'd1;
  localparam logic [CfgIdxW-1:0] RegDer = 3'd2;
  localparam logic [CfgIdxW-1:0] RegVarOn = 3'd3;
  localparam logic [CfgIdxW-1:0] RegRampW = 3'd4;
  localparam logic [CfgIdxW-1:0] RegBand = 3'd5;
  localparam logic [CfgIdxW-1:0] RegLimit = 3'd6;

  typedef enum logic [2:0] {
    StIdle, StErr, StRamp, StDiv, StMul, StAcc, StOut
  } state_e;
endpackage

FILE: src/mecanum_wheel_speed_pid.sv
// mecanum wheel speed pid top level
// usage:
// - input channel (in_valid_i / in_stall_o) carries one control tick: four
//   encoder counts and forward, sideways and turn setpoints
// - output channel (out_valid_o / out_stall_i) carries four signed drives
// - cfg channel (cfg_valid_i / cfg_ready_o) writes gains and limits while idle
// timing:
// - each wheel runs serially through one shared datapath
// - per wheel: error capture, ramp setup, ramp factor divide (restoring,
//   one quotient bit a cycle), three gain multiplies done as 16-step shift-add
//   (one gain bit a cycle), accumulate
// - the wheels run back to back; each drive is registered at its accumulate,
//   and out_valid_o is raised from the out state after the last wheel
// - one item in flight; the next is accepted the cycle after the result is
//   taken
// reset:
// - pid history and accumulators go to zero, cfg registers to their defaults
// stall:
// - the result holds in the output register while out_stall_i is high;
//   no new item is taken until it is delivered
module mecanum_wheel_speed_pid #(
  parameter int unsigned FRAC_BITS = mws_pkg::FracBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  logic signed [15:0] pulses_front_left_i,
  input  logic signed [15:0] pulses_front_right_i,
  input  logic signed [15:0] pulses_rear_left_i,
  input  logic signed [15:0] pulses_rear_right_i,
  input  logic signed [15:0] target_forward_i,
  input  logic signed [15:0] target_sideways_i,
  input  logic signed [15:0] target_turn_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output logic signed [15:0] drive_front_left_o,
  output logic signed [15:0] drive_front_right_o,
  output logic signed [15:0] drive_rear_left_o,
  output logic signed [15:0] drive_rear_right_o,
  input  logic cfg_valid_i,
  output logic cfg_ready_o,
  input  logic [mws_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import mws_pkg::*;
  `include "assert_macros.svh"

  // error is saturated to 32 bits, products widened for sum
  localparam int unsigned EW = 32;
  localparam int unsigned SW = 52;
  localparam int unsigned BW = 16 + FRAC_BITS + 1; // (a+b) scaled

  logic [15:0] kp_q, ki_q, kd_q, rampw_q, band_q;
  logic        varon_q;
  logic [14:0] lim_q;

  logic signed [EW-1:0] e1_q [Wheels];
  logic signed [EW-1:0] e2_q [Wheels];
  logic signed [EW-1:0] acc_q [Wheels];

  logic signed [15:0] pul_q [Wheels];
  logic signed [15:0] x_q, y_q;
  logic signed [EW-1:0] t_q;
  logic signed [15:0] drv_q [Wheels];

  state_e st_q, st_d;
  logic [1:0] w_q;
  logic [4:0] cnt_q;
  logic [1:0] ph_q; // multiply phase: p, i, d
  logic out_v_q;

  logic signed [EW-1:0] e_q, ed_q, edd_q;
  logic [16:0] k_q;           // ramp factor q16, 17 bits; below 65536 inside the ramp band
  logic [BW+16:0] rem_q;      // divider remainder
  logic [BW-1:0] den_q;
  logic [15:0] ieff_q;
  logic [15:0] mg_q;          // gain bits shifted out
  logic signed [SW-1:0] mc_q; // multiplicand shifted left
  logic signed [SW-1:0] sum_q;

  assign in_stall_o  = (st_q != StIdle) || out_v_q;
  assign cfg_ready_o = (st_q == StIdle);
  assign out_valid_o = out_v_q;
  assign drive_front_left_o  = drv_q[0];
  assign drive_front_right_o = drv_q[1];
  assign drive_rear_left_o   = drv_q[2];
  assign drive_rear_right_o  = drv_q[3];

  // turn term: clamp, then divide the scaled magnitude by five with a
  // reciprocal multiply, sign restored after (truncates toward zero)
  logic signed [15:0] zc;
  logic [15:0] zmag;
  logic [33:0] tprod;
  logic [EW-1:0] tmag;
  logic signed [EW-1:0] tz;
  always_comb begin
    if (target_turn_i > $signed(16'(TurnClamp))) zc = 16'(TurnClamp);
    else if (target_turn_i < -$signed(16'(TurnClamp))) zc = -$signed(16'(TurnClamp));
    else zc = target_turn_i;
    zmag  = zc[15] ? 16'(-zc) : 16'(zc);
    tprod = 34'(zmag) * 34'(TurnRecip);
    tmag  = EW'(tprod >> (TurnRecipSh - FRAC_BITS));
    tz    = zc[15] ? -$signed(tmag) : $signed(tmag);
  end

  // wheel error for current wheel
  logic signed [EW+1:0] tgt, err_w;
  logic signed [EW-1:0] err_s, mag;
  always_comb begin
    unique case (w_q)
      2'd0: tgt = ((EW+2)'(x_q) <<< FRAC_BITS) + ((EW+2)'(y_q) <<< FRAC_BITS) - t_q;
      2'd1: tgt = ((EW+2)'(x_q) <<< FRAC_BITS) - ((EW+2)'(y_q) <<< FRAC_BITS) + t_q;
      2'd2: tgt = ((EW+2)'(x_q) <<< FRAC_BITS) - ((EW+2)'(y_q) <<< FRAC_BITS) - t_q;
      default: tgt = ((EW+2)'(x_q) <<< FRAC_BITS) + ((EW+2)'(y_q) <<< FRAC_BITS) + t_q;
    endcase
    err_w = tgt - ((EW+2)'(pul_q[w_q]) <<< FRAC_BITS);
    if (err_w > (EW+2)'(32'sh7fffffff)) err_s = 32'sh7fffffff;
    else if (err_w < -(EW+2)'(34'sh80000000)) err_s = 32'sh80000000;
    else err_s = err_w[EW-1:0];
  end

  // band thresholds for ramp
  logic [BW-1:0] bsc, absc, emag;
  always_comb begin
    bsc  = BW'(band_q) << FRAC_BITS;
    absc = (BW'(rampw_q) + BW'(band_q)) << FRAC_BITS;
    mag  = e_q[EW-1] ? -e_q : e_q;
    emag = BW'(mag); // mag <= 2^31; compare with wide check below
  end
  logic big_mag;
  assign big_mag = (BW < 32) && (({1'b0, mag} >> BW) != 0);

  // restoring divider trial
  logic [BW+16:0] trial;
  assign trial = rem_q - ((BW+17)'(den_q) << cnt_q);

  // accumulator update, wide enough for the largest increment
  logic signed [SW-1:0] inc, nacc, limq;
  always_comb begin
    inc  = sum_q / 256;
    nacc = SW'(acc_q[w_q]) + inc;
    limq = $signed(SW'(lim_q) << FRAC_BITS);
    if (nacc > limq) nacc = limq;
    else if (nacc < -limq) nacc = -limq;
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle: if (in_valid_i && !in_stall_o) st_d = StErr;
      StErr:  st_d = StRamp;
      StRamp: st_d = StDiv;
      StDiv:  if (cnt_q == 5'd0) st_d = StMul;
      StMul:  if (cnt_q == 5'd15 && ph_q == 2'd2) st_d = StAcc;
      StAcc:  st_d = (w_q == 2'd3) ? StOut : StErr;
      StOut:  st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      kp_q <= '0; ki_q <= '0; kd_q <= '0; varon_q <= 1'b0;
      rampw_q <= 16'd100; band_q <= 16'd10; lim_q <= 15'd25000;
      out_v_q <= 1'b0;
      w_q <= '0; cnt_q <= '0; ph_q <= '0;
      for (int i = 0; i < Wheels; i++) begin
        e1_q[i] <= '0; e2_q[i] <= '0; acc_q[i] <= '0;
      end
    end else begin
      st_q <= st_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          RegProp:  kp_q <= cfg_data_i;
          RegInt:   ki_q <= cfg_data_i;
          RegDer:   kd_q <= cfg_data_i;
          RegVarOn: varon_q <= cfg_data_i[0];
          RegRampW: rampw_q <= cfg_data_i;
          RegBand:  band_q <= cfg_data_i;
          RegLimit: lim_q <= cfg_data_i[14:0];
          default: ;
        endcase
      end
      if (out_v_q && !out_stall_i) out_v_q <= 1'b0;
      unique case (st_q)
        StIdle: w_q <= '0;
        StErr: ;
        StRamp: begin
          cnt_q <= 5'd16;
          // k = 65536 * (absc - mag) / (A * 2^F)
          rem_q <= (BW+17)'(absc - emag) << 16;
          den_q <= BW'(rampw_q) << FRAC_BITS;
          k_q <= '0;
        end
        StDiv: begin
          if (trial[BW+16] == 1'b0) begin
            rem_q <= trial;
            k_q[cnt_q] <= 1'b1;
          end
          if (cnt_q == 5'd0) begin
            cnt_q <= '0;
            ph_q <= 2'd0;
            mg_q <= kp_q;
            mc_q <= SW'(ed_q);
            sum_q <= '0;
          end else begin
            cnt_q <= cnt_q - 5'd1;
          end
        end
        StMul: begin
          if (cnt_q == 5'd0 && ph_q == 2'd0) begin
            // first multiply cycle: quotient is final, pick the integral gain
            if (!varon_q) ieff_q <= ki_q;
            else if (big_mag || emag > absc || rampw_q == 16'd0) begin
              ieff_q <= (!big_mag && emag <= bsc) ? ki_q : 16'd0;
            end else if (emag <= bsc) ieff_q <= ki_q;
            else ieff_q <= 16'((33'(ki_q) * 33'(k_q)) >> 16);
          end
          if (mg_q[0]) sum_q <= sum_q + mc_q;
          if (cnt_q == 5'd15) begin
            cnt_q <= '0;
            ph_q <= ph_q + 2'd1;
            if (ph_q == 2'd0) begin mg_q <= ieff_q; mc_q <= SW'(e_q); end
            else begin mg_q <= kd_q; mc_q <= SW'(edd_q); end
          end else begin
            cnt_q <= cnt_q + 5'd1;
            mg_q <= mg_q >> 1;
            mc_q <= mc_q <<< 1;
          end
        end
        StAcc: begin
          acc_q[w_q] <= nacc[EW-1:0];
          e1_q[w_q] <= e_q;
          e2_q[w_q] <= e1_q[w_q];
          drv_q[w_q] <= 16'(nacc / SW'(1 << FRAC_BITS));
          w_q <= w_q + 2'd1;
        end
        StOut: out_v_q <= 1'b1;
        default: ;
      endcase
      if (st_q == StIdle && st_d == StErr) begin
        pul_q[0] <= pulses_front_left_i; pul_q[1] <= pulses_front_right_i;
        pul_q[2] <= pulses_rear_left_i;  pul_q[3] <= pulses_rear_right_i;
        x_q <= target_forward_i; y_q <= target_sideways_i; t_q <= tz;
      end
    end
  end

  // error of the current wheel, then its first and second differences
  always_ff @(posedge clk_i) begin
    if (st_q == StErr) e_q <= err_s;
    if (st_q == StRamp) begin
      ed_q  <= e_q - e1_q[w_q];
      edd_q <= e_q - (e1_q[w_q] <<< 1) + e2_q[w_q];
    end
  end

  `ASSERT_IMP(a_no_take_busy, clk_i, rst_ni, st_q != StIdle, in_stall_o, "accepted while busy")
  `ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_v_q && out_stall_i, out_v_q, "result dropped")
  `ASSERT_IMP(a_idle_out, clk_i, rst_ni, out_v_q, st_q == StIdle, "result while working")
endmodule
